// ===== sv/wrlf_pkg.sv =====
// ----------------------------------------------------------------------------
// wrlf_pkg
// shared constants, codes and controller/datapath types for the rate filter
// ----------------------------------------------------------------------------
`default_nettype none
package wrlf_pkg;
    localparam int WL_ENTRIES_DEF = 256;
    localparam int RT_ENTRIES_DEF = 256;

    localparam int IN_W  = 152;
    localparam int OUT_W = 8;
    localparam int WIN_W = 40;
    localparam int VAL_W = 80;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd1000000000;
    localparam logic [15:0]      IPV4_TYPE    = 16'h0800;
    localparam logic [15:0]      MIN_IPV4_LEN = 16'd34;

    localparam logic [2:0] CMD_PKT    = 3'd0;
    localparam logic [2:0] CMD_WL_ADD = 3'd1;
    localparam logic [2:0] CMD_WL_DEL = 3'd2;
    localparam logic [2:0] CMD_RT_WR  = 3'd3;
    localparam logic [2:0] CMD_RT_DEL = 3'd4;

    localparam logic [2:0] R_SHORT   = 3'd0;
    localparam logic [2:0] R_WHITE   = 3'd1;
    localparam logic [2:0] R_NOENTRY = 3'd2;
    localparam logic [2:0] R_COUNTED = 3'd3;
    localparam logic [2:0] R_OVER    = 3'd4;
    localparam logic [2:0] R_RESTART = 3'd5;
    localparam logic [2:0] R_CMD     = 3'd6;

    localparam logic [1:0] S_OK       = 2'd0;
    localparam logic [1:0] S_FULL     = 2'd1;
    localparam logic [1:0] S_NOTFOUND = 2'd2;

    typedef struct packed {
        logic       clr_en;
        logic       item_load;
        logic       start_scan;
        logic       scan_rate;
        logic       wl_set;
        logic       wl_clr;
        logic       rt_set;
        logic       rt_clr;
        logic       upd_restart;
        logic       upd_count;
        logic       out_load;
        logic       verdict;
        logic [2:0] reason;
        logic [1:0] status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [2:0] cmd;
        logic       short_pkt;
        logic       scan_rate;
        logic       scan_done;
        logic       found;
        logic       free_found;
        logic       in_window;
        logic       at_limit;
        logic       out_free;
    } dp_status_t;
endpackage
`default_nettype wire

// ===== sv/wrlf_ram.sv =====
// ----------------------------------------------------------------------------
// wrlf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module wrlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/wrlf_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrlf_ctrl
// sequencer for the reset clear, table scans, entry updates and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
module wrlf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire wrlf_pkg::dp_status_t st,
    output wrlf_pkg::ctrl_cmd_t       cmd
);
    import wrlf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       verdict_reg, verdict_next;
    logic [2:0] reason_reg, reason_next;
    logic [1:0] status_reg, status_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        reason_next  = reason_reg;
        status_next  = status_reg;
        cmd          = '0;
        cmd.verdict  = verdict_reg;
        cmd.reason   = reason_reg;
        cmd.status   = status_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DISP;
                end
            end
            ST_DISP: begin
                verdict_next = 1'b0;
                reason_next  = R_CMD;
                status_next  = S_OK;
                state_next   = ST_SCAN;
                case (st.cmd)
                    CMD_PKT: begin
                        if (st.short_pkt) begin
                            reason_next = R_SHORT;
                            state_next  = ST_RESP;
                        end else begin
                            cmd.start_scan = 1'b1;
                        end
                    end
                    CMD_WL_ADD, CMD_WL_DEL: begin
                        cmd.start_scan = 1'b1;
                    end
                    CMD_RT_WR, CMD_RT_DEL: begin
                        cmd.start_scan = 1'b1;
                        cmd.scan_rate  = 1'b1;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SCAN: begin
                if (st.scan_done) begin
                    state_next = ST_RESP;
                    case (st.cmd)
                        CMD_PKT: begin
                            if (!st.scan_rate) begin
                                if (st.found) begin
                                    reason_next = R_WHITE;
                                end else begin
                                    cmd.start_scan = 1'b1;
                                    cmd.scan_rate  = 1'b1;
                                    state_next     = ST_SCAN;
                                end
                            end else if (st.found) begin
                                state_next = ST_EVAL;
                            end else begin
                                verdict_next = 1'b1;
                                reason_next  = R_NOENTRY;
                            end
                        end
                        CMD_WL_ADD: begin
                            if (st.found || st.free_found) begin
                                cmd.wl_set = 1'b1;
                            end else begin
                                status_next = S_FULL;
                            end
                        end
                        CMD_WL_DEL: begin
                            if (st.found) begin
                                cmd.wl_clr = 1'b1;
                            end else begin
                                status_next = S_NOTFOUND;
                            end
                        end
                        CMD_RT_WR: begin
                            if (st.found || st.free_found) begin
                                cmd.rt_set = 1'b1;
                            end else begin
                                status_next = S_FULL;
                            end
                        end
                        CMD_RT_DEL: begin
                            if (st.found) begin
                                cmd.rt_clr = 1'b1;
                            end else begin
                                status_next = S_NOTFOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                state_next = ST_RESP;
                if (!st.in_window) begin
                    cmd.upd_restart = 1'b1;
                    reason_next     = R_RESTART;
                end else if (st.at_limit) begin
                    verdict_next = 1'b1;
                    reason_next  = R_OVER;
                end else begin
                    cmd.upd_count = 1'b1;
                    reason_next   = R_COUNTED;
                end
            end
            ST_RESP: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
        verdict_reg <= verdict_next;
        reason_reg  <= reason_next;
        status_reg  <= status_next;
    end
endmodule
`default_nettype wire

// ===== sv/wrlf_dp.sv =====
// ----------------------------------------------------------------------------
// wrlf_dp
// item register, key scan engine, entry stores, window check, output register
// ----------------------------------------------------------------------------
`default_nettype none
module wrlf_dp #(
    parameter int WL_ENTRIES = wrlf_pkg::WL_ENTRIES_DEF,
    parameter int RT_ENTRIES = wrlf_pkg::RT_ENTRIES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [wrlf_pkg::WIN_W-1:0]   cfg_wr_data,
    input  wire logic [wrlf_pkg::IN_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [wrlf_pkg::OUT_W-1:0]   m_tdata,
    input  wire wrlf_pkg::ctrl_cmd_t          cmd,
    output wrlf_pkg::dp_status_t              st
);
    import wrlf_pkg::*;

    localparam int WAW   = (WL_ENTRIES > 1) ? $clog2(WL_ENTRIES) : 1;
    localparam int RAW   = (RT_ENTRIES > 1) ? $clog2(RT_ENTRIES) : 1;
    localparam int SW    = (WAW > RAW) ? WAW : RAW;
    localparam int CLR_N = (WL_ENTRIES > RT_ENTRIES) ? WL_ENTRIES : RT_ENTRIES;
    localparam logic [SW-1:0] WL_LAST  = SW'(WL_ENTRIES - 1);
    localparam logic [SW-1:0] RT_LAST  = SW'(RT_ENTRIES - 1);
    localparam logic [SW-1:0] CLR_LAST = SW'(CLR_N - 1);

    logic [IN_W-1:0]   item_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [SW-1:0]     clr_idx_reg;
    logic [SW-1:0]     idx_reg, cmp_idx_reg, match_reg, free_reg;
    logic              issue_reg, cmp_v_reg, done_reg, found_reg, free_found_reg;
    logic              rate_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [2:0]  i_cmd;
    logic [31:0] i_src;
    logic [15:0] i_etype, i_flen;
    logic [63:0] i_time;
    logic [7:0]  i_lim, i_icnt;

    assign i_cmd   = item_reg[2:0];
    assign i_src   = item_reg[34:3];
    assign i_etype = item_reg[50:35];
    assign i_flen  = item_reg[66:51];
    assign i_time  = item_reg[130:67];
    assign i_lim   = item_reg[138:131];
    assign i_icnt  = item_reg[146:139];

    // key store words: valid bit, key
    logic [32:0]      wl_key_rd, rt_key_rd, key_wdata;
    logic [SW-1:0]    key_waddr;
    logic [VAL_W-1:0] val_rd, val_wdata;
    logic [SW-1:0]    last, set_idx;
    logic             cmp_valid, cmp_hit;
    logic [63:0]      diff;

    assign last      = rate_reg ? RT_LAST : WL_LAST;
    assign set_idx   = found_reg ? match_reg : free_reg;
    assign key_waddr = cmd.clr_en ? clr_idx_reg : set_idx;
    assign key_wdata = cmd.clr_en ? 33'd0 : {cmd.wl_set | cmd.rt_set, i_src};

    wrlf_ram #(.WIDTH(33), .DEPTH(WL_ENTRIES)) u_wl_key (
        .aclk(aclk), .we(cmd.clr_en || cmd.wl_set || cmd.wl_clr),
        .waddr(key_waddr[WAW-1:0]), .wdata(key_wdata),
        .raddr(idx_reg[WAW-1:0]), .rdata(wl_key_rd)
    );

    wrlf_ram #(.WIDTH(33), .DEPTH(RT_ENTRIES)) u_rt_key (
        .aclk(aclk), .we(cmd.clr_en || cmd.rt_set || cmd.rt_clr),
        .waddr(key_waddr[RAW-1:0]), .wdata(key_wdata),
        .raddr(idx_reg[RAW-1:0]), .rdata(rt_key_rd)
    );

    always_comb begin
        if (cmd.rt_set) begin
            val_wdata = {i_lim, i_icnt, i_time};
        end else if (cmd.upd_restart) begin
            val_wdata = {val_rd[79:72], 8'd1, i_time};
        end else begin
            val_wdata = {val_rd[79:72], val_rd[71:64] + 8'd1, val_rd[63:0]};
        end
    end

    wrlf_ram #(.WIDTH(VAL_W), .DEPTH(RT_ENTRIES)) u_rt_val (
        .aclk(aclk), .we(cmd.rt_set || cmd.upd_restart || cmd.upd_count),
        .waddr(set_idx[RAW-1:0]), .wdata(val_wdata),
        .raddr(match_reg[RAW-1:0]), .rdata(val_rd)
    );

    assign cmp_valid = rate_reg ? rt_key_rd[32] : wl_key_rd[32];
    assign cmp_hit   = cmp_valid && ((rate_reg ? rt_key_rd[31:0] : wl_key_rd[31:0]) == i_src);
    assign diff      = i_time - val_rd[63:0];

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_tdata;
        end
        if (cmd.start_scan) begin
            idx_reg  <= '0;
            rate_reg <= cmd.scan_rate;
        end else if (issue_reg && idx_reg != last) begin
            idx_reg <= idx_reg + 1'b1;
        end
        cmp_idx_reg <= idx_reg;
        if (cmp_v_reg && cmp_hit && !found_reg) begin
            match_reg <= cmp_idx_reg;
        end
        if (cmp_v_reg && !cmp_valid && !free_found_reg) begin
            free_reg <= cmp_idx_reg;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, cmd.status, cmd.reason, cmd.verdict};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= WINDOW_RESET;
            clr_idx_reg    <= '0;
            issue_reg      <= 1'b0;
            cmp_v_reg      <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (cmd.clr_en && clr_idx_reg != CLR_LAST) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.start_scan) begin
                issue_reg      <= 1'b1;
                cmp_v_reg      <= 1'b0;
                done_reg       <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (issue_reg && idx_reg == last) begin
                    issue_reg <= 1'b0;
                end
                cmp_v_reg <= issue_reg;
                done_reg  <= cmp_v_reg && (cmp_idx_reg == last);
                if (cmp_v_reg && cmp_hit) begin
                    found_reg <= 1'b1;
                end
                if (cmp_v_reg && !cmp_valid) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        st            = '0;
        st.clr_last   = (clr_idx_reg == CLR_LAST);
        st.cmd        = i_cmd;
        st.short_pkt  = (i_flen < MIN_IPV4_LEN) || (i_etype != IPV4_TYPE);
        st.scan_rate  = rate_reg;
        st.scan_done  = done_reg;
        st.found      = found_reg;
        st.free_found = free_found_reg;
        st.in_window  = diff < {24'd0, window_reg};
        st.at_limit   = val_rd[71:64] >= val_rd[79:72];
        st.out_free   = !m_tvalid_reg || m_tready;
    end
endmodule
`default_nettype wire

// ===== sv/whitelist_rate_limit_filter.sv =====
// result path to m_tvalid: short or non-ipv4 packets and unknown commands skip the key
// scans, whitelist commands and whitelisted packets scan the whitelist, rate commands scan
// the rate table, and a rate-checked packet scans both and then checks its window
// flow: one request at a time; the next is accepted in the cycle after the result load
// reset: synchronous active-low aresetn restores the 1000000000 ns window, then a pass over
// max(WL_ENTRIES, RT_ENTRIES) entries clears the valid bits while s_tready is low
// ----------------------------------------------------------------------------
// whitelist_rate_limit_filter
// per-source fixed window rate limiter with a source whitelist
// ----------------------------------------------------------------------------
`default_nettype none
module whitelist_rate_limit_filter #(
    parameter int WL_ENTRIES = wrlf_pkg::WL_ENTRIES_DEF,
    parameter int RT_ENTRIES = wrlf_pkg::RT_ENTRIES_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [wrlf_pkg::WIN_W-1:0] cfg_wr_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // cmd, source_address, ether_type, frame_length, time_ns, packet_limit,
    // initial_count, zero pad
    input  wire logic [wrlf_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // verdict, reason, status, zero pad
    output logic      [wrlf_pkg::OUT_W-1:0] m_tdata
);
    import wrlf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    wrlf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .st(st), .cmd(cmd)
    );

    wrlf_dp #(.WL_ENTRIES(WL_ENTRIES), .RT_ENTRIES(RT_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cmd(cmd), .st(st)
    );
endmodule
`default_nettype wire

// ===== tb/wrlf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrlf_checker
// watches both streams of the rate filter, predicts each verdict from its own
// copy of the whitelist and rate tables, and compares results in order
// ----------------------------------------------------------------------------
`default_nettype none
module wrlf_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [wrlf_pkg::WIN_W-1:0] cfg_wr_data,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [wrlf_pkg::IN_W-1:0]  s_tdata,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [wrlf_pkg::OUT_W-1:0] m_tdata,
    output int                              errors,
    output int                              pending,
    output int                              checked
);
    import wrlf_pkg::*;

    bit [31:0]      wl_key  [WL_ENTRIES_DEF];
    bit             wl_vld  [WL_ENTRIES_DEF];
    bit [31:0]      rt_key  [RT_ENTRIES_DEF];
    bit             rt_vld  [RT_ENTRIES_DEF];
    bit [63:0]      win_beg [RT_ENTRIES_DEF];
    bit [7:0]       pkt_cnt [RT_ENTRIES_DEF];
    bit [7:0]       pkt_lim [RT_ENTRIES_DEF];
    bit [WIN_W-1:0] win_len;

    logic [5:0] verdict_q[$];
    int n_err = 0;
    int n_chk = 0;

    assign errors  = n_err;
    assign pending = verdict_q.size();
    assign checked = n_chk;

    task automatic report(input string what, input int got, input int want);
        n_err++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic int find_wl(input bit [31:0] k);
        for (int i = 0; i < WL_ENTRIES_DEF; i++)
            if (wl_vld[i] && wl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int find_rt(input bit [31:0] k);
        for (int i = 0; i < RT_ENTRIES_DEF; i++)
            if (rt_vld[i] && rt_key[i] == k) return i;
        return -1;
    endfunction

    // returns {status, reason, verdict}
    task automatic judge_request(input logic [IN_W-1:0] d, output logic [5:0] res);
        logic [2:0]  cmd;
        logic [31:0] src;
        logic [15:0] etype;
        logic [15:0] flen;
        logic [63:0] now;
        logic [7:0]  lim;
        logic [7:0]  icnt;
        logic        verdict;
        logic [2:0]  reason;
        logic [1:0]  status;
        int          i;
        cmd   = d[2:0];
        src   = d[34:3];
        etype = d[50:35];
        flen  = d[66:51];
        now   = d[130:67];
        lim   = d[138:131];
        icnt  = d[146:139];
        verdict = 1'b0;
        reason  = R_CMD;
        status  = S_OK;
        case (cmd)
            CMD_PKT: begin
                if (etype != IPV4_TYPE || flen < MIN_IPV4_LEN) begin
                    reason = R_SHORT;
                end else if (find_wl(src) >= 0) begin
                    reason = R_WHITE;
                end else begin
                    i = find_rt(src);
                    if (i < 0) begin
                        verdict = 1'b1;
                        reason  = R_NOENTRY;
                    end else if (now - win_beg[i] < {24'd0, win_len}) begin
                        if (pkt_cnt[i] >= pkt_lim[i]) begin
                            verdict = 1'b1;
                            reason  = R_OVER;
                        end else begin
                            pkt_cnt[i]++;
                            reason = R_COUNTED;
                        end
                    end else begin
                        win_beg[i] = now;
                        pkt_cnt[i] = 8'd1;
                        reason     = R_RESTART;
                    end
                end
            end
            CMD_WL_ADD: begin
                i = find_wl(src);
                if (i < 0)
                    for (int j = WL_ENTRIES_DEF - 1; j >= 0; j--)
                        if (!wl_vld[j]) i = j;
                if (i < 0) begin
                    status = S_FULL;
                end else begin
                    wl_key[i] = src;
                    wl_vld[i] = 1'b1;
                end
            end
            CMD_WL_DEL: begin
                i = find_wl(src);
                if (i < 0) status = S_NOTFOUND;
                else wl_vld[i] = 1'b0;
            end
            CMD_RT_WR: begin
                i = find_rt(src);
                if (i < 0)
                    for (int j = RT_ENTRIES_DEF - 1; j >= 0; j--)
                        if (!rt_vld[j]) i = j;
                if (i < 0) begin
                    status = S_FULL;
                end else begin
                    rt_key[i]  = src;
                    rt_vld[i]  = 1'b1;
                    win_beg[i] = now;
                    pkt_cnt[i] = icnt;
                    pkt_lim[i] = lim;
                end
            end
            CMD_RT_DEL: begin
                i = find_rt(src);
                if (i < 0) status = S_NOTFOUND;
                else rt_vld[i] = 1'b0;
            end
            default: ;
        endcase
        res = {status, reason, verdict};
    endtask

    always @(posedge aclk) begin
        logic [5:0] res;
        logic [5:0] want;
        if (!aresetn) begin
            for (int i = 0; i < WL_ENTRIES_DEF; i++) wl_vld[i] = 1'b0;
            for (int i = 0; i < RT_ENTRIES_DEF; i++) rt_vld[i] = 1'b0;
            win_len = WINDOW_RESET;
            verdict_q.delete();
        end else begin
            if (cfg_wr_en) win_len = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    want = verdict_q.pop_front();
                    n_chk++;
                    if (m_tdata[0] !== want[0]) report("verdict", m_tdata[0], want[0]);
                    if (m_tdata[3:1] !== want[3:1]) report("reason", m_tdata[3:1], want[3:1]);
                    if (m_tdata[5:4] !== want[5:4]) report("status", m_tdata[5:4], want[5:4]);
                end
            end
            if (s_tvalid && s_tready) begin
                judge_request(s_tdata, res);
                verdict_q.push_back(res);
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_whitelist_rate_limit_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_whitelist_rate_limit_filter
// directed and random requests through the rate filter: header checks,
// whitelist and rate table commands, a full whitelist, window expiry across
// several window lengths, with bursty input and a stalling result side
// ----------------------------------------------------------------------------
`default_nettype none
module tb_whitelist_rate_limit_filter;
    import wrlf_pkg::*;

    localparam int SETTLE_CYCLES = WL_ENTRIES_DEF + RT_ENTRIES_DEF + 40;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [WIN_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int errors;
    int pending;
    int checked;

    logic        long_hold = 1'b0;
    int          burst_left = 0;
    int          n_sent = 0;
    int          n_settings = 1;
    logic [63:0] win_len = 64'd1000000000;
    logic [63:0] clock_ns;
    logic [31:0] key_pool[12];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    whitelist_rate_limit_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    wrlf_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending), .checked(checked)
    );

    // receiver: ready for the first quarter of each rx_phase frame, except during the long hold-off
    always @(posedge aclk) begin
        int rx_phase;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_phase = 0;
        end else begin
            rx_phase = (rx_phase + 1) % 64;
            if (long_hold) m_tready <= 1'b0;
            else m_tready <= (rx_phase < 16) || ($urandom_range(0, 9) < 6);
        end
    end

    // long receiver hold-off while requests keep coming
    initial begin
        repeat (20000) @(posedge aclk);
        long_hold <= 1'b1;
        repeat (3000) @(posedge aclk);
        long_hold <= 1'b0;
    end

    initial begin
        #50ms;
        $display("whitelist_rate_limit_filter test failed");
        $finish;
    end

    function automatic logic [IN_W-1:0] pack(input logic [2:0] cmd, input logic [31:0] src,
        input logic [15:0] etype, input logic [15:0] flen, input logic [63:0] t,
        input logic [7:0] lim, input logic [7:0] icnt);
        return {5'd0, icnt, lim, t, flen, etype, src, cmd};
    endfunction

    task automatic send(input logic [IN_W-1:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        n_sent++;
    endtask

    task automatic pkt(input logic [31:0] src, input logic [15:0] flen, input logic [63:0] t);
        send(pack(CMD_PKT, src, IPV4_TYPE, flen, t, 8'd0, 8'd0));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_len = {24'd0, v};
        n_settings++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] step_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return clock_ns + rand64() % (win_len / 4 + 1);
        if (r < 8) return clock_ns + win_len - 2 + $urandom_range(0, 3);
        return rand64();
    endfunction

    task automatic random_request();
        int          r;
        logic [31:0] src;
        logic [7:0]  lim;
        logic [7:0]  icnt;
        r    = $urandom_range(0, 99);
        src  = key_pool[$urandom_range(0, 11)];
        lim  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        icnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        if (r < 55) begin
            clock_ns = step_time();
            pkt(src, ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(34, 1518)),
                clock_ns);
        end else if (r < 62) begin
            send(pack(CMD_PKT, $urandom, 16'($urandom), 16'($urandom), rand64(),
                      8'($urandom), 8'($urandom)));
        end else if (r < 70) begin
            send(pack(CMD_WL_ADD, src, 16'($urandom), 16'($urandom), rand64(),
                      8'($urandom), 8'($urandom)));
        end else if (r < 76) begin
            send(pack(CMD_WL_DEL, src, 16'($urandom), 16'($urandom), rand64(),
                      8'($urandom), 8'($urandom)));
        end else if (r < 88) begin
            send(pack(CMD_RT_WR, src, 16'($urandom), 16'($urandom),
                      ($urandom_range(0, 4) == 0) ? rand64() : clock_ns - $urandom_range(0, 50),
                      lim, icnt));
        end else if (r < 94) begin
            send(pack(CMD_RT_DEL, src, 16'($urandom), 16'($urandom), rand64(),
                      8'($urandom), 8'($urandom)));
        end else if (r < 97) begin
            send(pack(3'($urandom_range(5, 7)), $urandom, 16'($urandom), 16'($urandom),
                      rand64(), 8'($urandom), 8'($urandom)));
        end else begin
            send(pack(CMD_PKT, src, IPV4_TYPE, 16'($urandom), rand64(),
                      8'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        logic [31:0] ka;
        logic [31:0] kb;
        logic [31:0] kc;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [WIN_W-1:0] windows[5];
        ka = 32'hffffffff;
        kb = 32'h00000000;
        kc = 32'h80000001;
        key_pool[0] = ka;
        key_pool[1] = kb;
        key_pool[2] = kc;
        // keys that sit in the filled whitelist
        key_pool[3] = 32'h1000_0000;
        key_pool[4] = 32'h1000_0064;
        key_pool[5] = 32'h1000_00ff;
        for (int i = 6; i < 12; i++) key_pool[i] = $urandom;
        t0 = 64'h0000_1234_5678_0000;
        t1 = 64'h0000_0000_0000_0010;
        windows[0] = 40'd1;
        windows[1] = 40'd1000;
        windows[2] = 40'hff_ffff_ffff;
        windows[3] = 40'd0;
        windows[4] = 40'($urandom_range(1, 2000000));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // header checks, no entry, unknown commands
        pkt(ka, 16'd0, t0);
        pkt(ka, 16'd13, t0);
        pkt(ka, 16'd33, t0);
        send(pack(CMD_PKT, ka, 16'h86dd, 16'd64, t0, 8'd0, 8'd0));
        pkt(ka, 16'd34, t0);
        for (int c = 5; c < 8; c++) send(pack(3'(c), ka, 16'd0, 16'd0, t0, 8'd0, 8'd0));
        // whitelist add, update in place, remove
        send(pack(CMD_WL_DEL, ka, 16'd0, 16'd0, t0, 8'd0, 8'd0));
        send(pack(CMD_WL_ADD, ka, 16'd0, 16'd0, t0, 8'd0, 8'd0));
        send(pack(CMD_WL_ADD, ka, 16'd0, 16'd0, t0, 8'd0, 8'd0));
        pkt(ka, 16'hffff, t0);
        send(pack(CMD_WL_DEL, ka, 16'd0, 16'd0, t0, 8'd0, 8'd0));
        // rate window: count, over limit, restart
        send(pack(CMD_RT_DEL, kb, 16'd0, 16'd0, t0, 8'd0, 8'd0));
        send(pack(CMD_RT_WR, kb, 16'd0, 16'd0, t0, 8'd2, 8'd0));
        pkt(kb, 16'd100, t0 + 5);
        pkt(kb, 16'd100, t0 + 6);
        pkt(kb, 16'd100, t0 + 7);
        pkt(kb, 16'd100, t0 + 64'd1000000000);
        // zero limit and wrapping time difference
        send(pack(CMD_RT_WR, kb, 16'd0, 16'd0, t1, 8'd0, 8'd0));
        pkt(kb, 16'd100, t1 + 1);
        pkt(kb, 16'd100, t1 - 1);
        send(pack(CMD_RT_WR, kc, 16'd0, 16'd0, 64'd0, 8'd255, 8'd255));
        pkt(kc, 16'd100, 64'hffff_ffff_ffff_ffff);
        send(pack(CMD_RT_DEL, kb, 16'd0, 16'd0, t0, 8'd0, 8'd0));

        // fill the whitelist, one insert past full; it stays mostly full
        for (int i = 0; i <= WL_ENTRIES_DEF; i++)
            send(pack(CMD_WL_ADD, 32'h1000_0000 + i, 16'd0, 16'd0, t0, 8'd0, 8'd0));

        clock_ns = rand64();
        for (int p = 0; p < 6; p++) begin
            if (p > 0) set_window(windows[p-1]);
            for (int n = 0; n < 28; n++) random_request();
        end

        settle();
        $display("sent %0d requests over %0d window settings, %0d results checked",
                 n_sent, n_settings, checked);
        if (errors == 0 && pending == 0) begin
            $display("whitelist_rate_limit_filter test passed");
        end else begin
            $display("whitelist_rate_limit_filter test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
